FILE: design/nodata_pixel_mask_macros.svh
// Assertion macros for the no-data pixel mask checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef NODATA_PIXEL_MASK_MACROS_SVH
`define NODATA_PIXEL_MASK_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define NPM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nodata_pixel_mask: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define NPM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nodata_pixel_mask: next-cycle check failed");

// Next-cycle implication that also runs through reset.
`define NPM_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("nodata_pixel_mask: reset check failed");

`endif

FILE: design/npm_pkg.sv
// Shared types and constants of the no-data pixel mask block.
// No dependencies; used by npm_regs, npm_match and nodata_pixel_mask.
`default_nettype none

package npm_pkg;

  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 3;

  // Layout of the register map: slab-major interval registers.
  localparam int REG_SLABS    = 2;
  localparam int REG_BANDS    = 3;
  localparam int REG_IVL_BASE = 2;

  localparam logic [IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [IDX_W-1:0] REG_SLAB_CNT = 3'd1;

  typedef struct packed {
    logic       mode;      // 1: intervals mark valid data
    logic [1:0] slab_cnt;  // raw active-slab count
  } cfg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] hi;
    logic signed [VAL_W-1:0] lo;
  } ivl_t;

endpackage

`default_nettype wire

FILE: design/npm_regs.sv
// APB-style configuration registers: mode, slab count and interval table.
// Depends on npm_pkg.
`default_nettype none

module npm_regs #(
  parameter int MAX_SLABS = 2,
  parameter int NUM_BANDS = 3
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [npm_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [npm_pkg::DATA_W-1:0]       pwdata,
  output logic      [npm_pkg::DATA_W-1:0]       prdata,
  output logic                                  pready,
  output npm_pkg::cfg_t                         cfg,
  output npm_pkg::ivl_t [MAX_SLABS-1:0][NUM_BANDS-1:0] ivl
);

  logic                                          mode_r;
  logic [1:0]                                    cnt_r;
  npm_pkg::ivl_t [MAX_SLABS-1:0][NUM_BANDS-1:0]  ivl_r;
  logic [npm_pkg::IDX_W-1:0]                     idx;
  logic                                          wr_en;

  assign idx    = paddr[npm_pkg::ADDR_W-1:npm_pkg::ADDR_W-npm_pkg::IDX_W];
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      cnt_r  <= 2'd0;
      ivl_r  <= '0;
    end else if (wr_en) begin
      case (idx)
        npm_pkg::REG_MODE:     mode_r <= pwdata[0];
        npm_pkg::REG_SLAB_CNT: cnt_r  <= pwdata[1:0];
        default: begin
          for (int s = 0; s < MAX_SLABS; s++) begin
            for (int b = 0; b < NUM_BANDS; b++) begin
              if (int'(idx) == npm_pkg::REG_IVL_BASE + s * npm_pkg::REG_BANDS + b) begin
                ivl_r[s][b] <= pwdata;
              end
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      npm_pkg::REG_MODE:     prdata = {{(npm_pkg::DATA_W-1){1'b0}}, mode_r};
      npm_pkg::REG_SLAB_CNT: prdata = {{(npm_pkg::DATA_W-2){1'b0}}, cnt_r};
      default: begin
        for (int s = 0; s < MAX_SLABS; s++) begin
          for (int b = 0; b < NUM_BANDS; b++) begin
            if (int'(idx) == npm_pkg::REG_IVL_BASE + s * npm_pkg::REG_BANDS + b) begin
              prdata = ivl_r[s][b];
            end
          end
        end
      end
    endcase
  end

  assign cfg = '{mode: mode_r, slab_cnt: cnt_r};
  assign ivl = ivl_r;

endmodule

`default_nettype wire

FILE: design/npm_match.sv
// Band flag logic: interval compare over active slabs, inversion, NaN force.
// Depends on npm_pkg.
`default_nettype none

module npm_match #(
  parameter int MAX_SLABS   = 2,
  parameter int NUM_BANDS   = 3,
  parameter int SAMPLE_BITS = 32
) (
  input  wire npm_pkg::cfg_t                                cfg,
  input  wire npm_pkg::ivl_t [MAX_SLABS-1:0][NUM_BANDS-1:0] ivl,
  input  wire logic [1:0]                                   band,
  input  wire logic signed [SAMPLE_BITS-1:0]                smp,
  input  wire logic                                         is_nan,
  output logic                                              band_flag
);

  logic signed [npm_pkg::VAL_W-1:0] x;
  logic [MAX_SLABS-1:0]             slab_on;
  logic                             hit;

  assign x = npm_pkg::VAL_W'(smp);

  // Clamp the slab count to what is built.
  always_comb begin
    for (int s = 0; s < MAX_SLABS; s++) begin
      slab_on[s] = (int'(cfg.slab_cnt) > s);
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int s = 0; s < MAX_SLABS; s++) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        if (slab_on[s] && (int'(band) == b) &&
            (x >= ivl[s][b].lo) && (x <= ivl[s][b].hi)) begin
          hit = 1'b1;
        end
      end
    end
  end

  assign band_flag = is_nan || (hit ^ cfg.mode);

endmodule

`default_nettype wire

FILE: design/nodata_pixel_mask.sv
// A transaction passes the input register, then the result register, before result valid.
// Throughput: one band sample per cycle while in_stall is low; the interval compare and
// pixel aggregation sit in a single combinational stage between the two registers.
// Reset (rst_n low, synchronous): both stages empty, pixel state at pixel start,
// all configuration registers cleared to 0.
`default_nettype none

module nodata_pixel_mask #(
  parameter int MAX_SLABS   = 2,
  parameter int NUM_BANDS   = 3,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Sample input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_band_index,
  input  wire logic signed [31:0]           in_sample_value,
  input  wire logic                         in_sample_is_nan,
  input  wire logic                         in_last_band,
  // Result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_band_flag,
  output logic                              out_pixel_flag,
  output logic                              out_pixel_done,
  // Configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [npm_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [npm_pkg::DATA_W-1:0]   pwdata,
  output logic      [npm_pkg::DATA_W-1:0]   prdata,
  output logic                              pready
);

  npm_pkg::cfg_t                                cfg;
  npm_pkg::ivl_t [MAX_SLABS-1:0][NUM_BANDS-1:0] ivl;

  // Input stage
  logic                           s1_valid_r;
  logic [1:0]                     s1_band_r;
  logic signed [SAMPLE_BITS-1:0]  s1_smp_r;
  logic                           s1_nan_r;
  logic                           s1_last_r;

  // Result stage
  logic                           out_valid_r;
  logic                           out_band_flag_r;
  logic                           out_pixel_flag_r;
  logic                           out_pixel_done_r;

  // Running pixel state
  logic                           accum_r, accum_nxt;
  logic                           at_start_r, at_start_nxt;

  logic                           out_open;   // result register can take a transaction
  logic                           s1_adv;     // input stage moves into result register
  logic                           in_take;    // input transaction accepted
  logic                           band_flag;
  logic                           acc_base;
  logic                           pix_flag;

  npm_regs #(
    .MAX_SLABS (MAX_SLABS),
    .NUM_BANDS (NUM_BANDS)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .ivl     (ivl)
  );

  npm_match #(
    .MAX_SLABS   (MAX_SLABS),
    .NUM_BANDS   (NUM_BANDS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_match (
    .cfg       (cfg),
    .ivl       (ivl),
    .band      (s1_band_r),
    .smp       (s1_smp_r),
    .is_nan    (s1_nan_r),
    .band_flag (band_flag)
  );

  // Handshake: the result register frees when it is empty or its transaction is taken;
  // the input stage frees when it is empty or it advances. Stall only with both full.
  assign out_open = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_open;
  assign in_stall = s1_valid_r && !out_open;
  assign in_take  = in_valid && !in_stall;

  // Aggregate: a new pixel opens at 1 (AND, no-data mode) or 0 (OR, valid-range mode).
  assign acc_base = at_start_r ? !cfg.mode : accum_r;
  assign pix_flag = cfg.mode ? (acc_base || band_flag) : (acc_base && band_flag);

  // Close the pixel on its last band; otherwise carry the running flag forward.
  always_comb begin
    accum_nxt    = accum_r;
    at_start_nxt = at_start_r;
    if (s1_adv) begin
      accum_nxt    = s1_last_r ? 1'b0 : pix_flag;
      at_start_nxt = s1_last_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      accum_r     <= 1'b0;
      at_start_r  <= 1'b1;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      accum_r    <= accum_nxt;
      at_start_r <= at_start_nxt;
    end
  end

  // Payload: load the input stage on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_band_r <= in_band_index;
      s1_smp_r  <= in_sample_value[SAMPLE_BITS-1:0];
      s1_nan_r  <= in_sample_is_nan;
      s1_last_r <= in_last_band;
    end
  end

  // Payload: load the result register when the input stage advances.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_band_flag_r  <= band_flag;
      out_pixel_flag_r <= pix_flag;
      out_pixel_done_r <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_band_flag  = out_band_flag_r;
  assign out_pixel_flag = out_pixel_flag_r;
  assign out_pixel_done = out_pixel_done_r;

endmodule

`default_nettype wire

FILE: design/npm_chk.sv
// Port-level checker for nodata_pixel_mask, attached by bind.
// Depends on nodata_pixel_mask_macros.svh.
`default_nettype none
`include "nodata_pixel_mask_macros.svh"

module npm_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_band_flag,
  input wire logic out_pixel_flag,
  input wire logic out_pixel_done
);

  logic first_r;  // next result transaction opens a pixel

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (out_valid && !out_stall) begin
      first_r <= out_pixel_done;
    end
  end

  `NPM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_band_flag) && $stable(out_pixel_flag) && $stable(out_pixel_done))
  `NPM_ASSERT_IMP(a_open_pixel, out_valid && !out_stall && first_r, out_pixel_flag == out_band_flag)
  `NPM_ASSERT_IMP(a_stall_full, in_stall, out_valid && out_stall)
  `NPM_ASSERT_RST(a_rst_empty, !rst_n, !out_valid && !in_stall)

endmodule

bind nodata_pixel_mask npm_chk u_npm_chk (.*);

`default_nettype wire

FILE: sim/nodata_pixel_mask_test.sv
`timescale 1ns / 100ps
// Self-checking bench for nodata_pixel_mask: directed and random band samples, checked
// per field against an in-bench classifier. Depends on npm_pkg and the block's RTL.

module nodata_pixel_mask_test;

  localparam int MAX_SLABS   = 2;
  localparam int NUM_BANDS   = 3;
  localparam int PHASE_ITEMS = 330;     // random samples per register setting
  localparam int QUIET_FROM  = 1800;    // no idling on either side after this many samples
  localparam int LONG_HOLD_AT = 500;    // result count that triggers the long receiver hold
  localparam int LONG_HOLD_LEN = 80;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;

  // One band sample as it crosses the input channel.
  typedef struct packed {
    logic [1:0]         band;
    logic signed [31:0] value;
    logic               is_nan;
    logic               last;
  } band_sample_t;

  // One result as it crosses the output channel.
  typedef struct packed {
    logic band_flag;
    logic pixel_flag;
    logic pixel_done;
  } mask_result_t;

  // Clock, reset and block ports; every input starts at a known value.
  logic clk;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_band_index = '0;
  logic signed [31:0] in_sample_value = '0;
  logic in_sample_is_nan = 1'b0;
  logic in_last_band = 1'b0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic out_band_flag;
  logic out_pixel_flag;
  logic out_pixel_done;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [npm_pkg::ADDR_W-1:0] paddr = '0;
  logic [npm_pkg::DATA_W-1:0] pwdata = '0;
  logic [npm_pkg::DATA_W-1:0] prdata;
  logic pready;

  // Bench bookkeeping.
  band_sample_t sample_backlog[$];    // samples waiting to be driven
  mask_result_t pending_results[$];   // predicted results, oldest first
  int accepted_count = 0;
  int results_seen = 0;
  int mismatches = 0;
  int pixels_closed = 0;
  int flags_raised = 0;
  int settings_count = 0;
  int idle_pct = 0;                   // chance in percent of starting an idle burst
  int cycle_count = 0;
  logic quiet_tail;

  // Classifier copy of the configuration and pixel state.
  npm_pkg::cfg_t cfg_m = '0;
  npm_pkg::ivl_t ivl_m [npm_pkg::REG_SLABS][npm_pkg::REG_BANDS];
  npm_pkg::ivl_t ivl_next [npm_pkg::REG_SLABS][npm_pkg::REG_BANDS];
  logic accum_m = 1'b0;
  logic pixel_start_m = 1'b1;

  assign quiet_tail = (accepted_count >= QUIET_FROM);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  nodata_pixel_mask dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_band_index    (in_band_index),
    .in_sample_value  (in_sample_value),
    .in_sample_is_nan (in_sample_is_nan),
    .in_last_band     (in_last_band),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_band_flag    (out_band_flag),
    .out_pixel_flag   (out_pixel_flag),
    .out_pixel_done   (out_pixel_done),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Classify one accepted sample and advance the pixel state. The interval test uses the
  // slabs that are active now; a slab count above the maximum counts as the maximum, and an
  // out-of-range band matches nothing but still gets inversion and NaN forcing.
  function automatic mask_result_t classify_sample(band_sample_t smp);
    mask_result_t res;
    logic hit;
    logic acc;
    int active_slabs;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    hit = 1'b0;
    active_slabs = (cfg_m.slab_cnt > MAX_SLABS) ? MAX_SLABS : int'(cfg_m.slab_cnt);
    if (smp.band < NUM_BANDS) begin
      for (int s = 0; s < active_slabs; s++) begin
        lo = ivl_m[s][smp.band].lo;
        hi = ivl_m[s][smp.band].hi;
        if (smp.value >= lo && smp.value <= hi)
          hit = 1'b1;
      end
    end
    if (cfg_m.mode)
      hit = ~hit;
    if (smp.is_nan)
      hit = 1'b1;
    // A new pixel opens at 1 for the AND in no-data mode, at 0 for the OR in valid-range mode.
    acc = pixel_start_m ? ~cfg_m.mode : accum_m;
    acc = cfg_m.mode ? (acc | hit) : (acc & hit);
    res.band_flag = hit;
    res.pixel_flag = acc;
    res.pixel_done = smp.last;
    if (smp.last) begin
      accum_m = 1'b0;
      pixel_start_m = 1'b1;
    end else begin
      accum_m = acc;
      pixel_start_m = 1'b0;
    end
    return res;
  endfunction

  // Sample driver: advance on acceptance or while idle, insert random idle bursts, and record
  // the prediction for every accepted transaction.
  always @(posedge clk) begin : sample_driver
    band_sample_t nxt;
    band_sample_t cur;
    int tx_gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_band_index <= '0;
      in_sample_value <= '0;
      in_sample_is_nan <= 1'b0;
      in_last_band <= 1'b0;
      tx_gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        cur = '{in_band_index, in_sample_value, in_sample_is_nan, in_last_band};
        pending_results = {pending_results, classify_sample(cur)};
        accepted_count <= accepted_count + 1;
      end
      // Hold the payload while stalled; otherwise pick the next cycle's content.
      if (!in_valid || !in_stall) begin
        if (tx_gap_left != 0) begin
          in_valid <= 1'b0;
          tx_gap_left = tx_gap_left - 1;
        end else if (!quiet_tail && $urandom_range(99) < idle_pct) begin
          in_valid <= 1'b0;
          tx_gap_left = $urandom_range(7);
        end else if (sample_backlog.size() != 0) begin
          nxt = sample_backlog.pop_front();
          in_valid <= 1'b1;
          in_band_index <= nxt.band;
          in_sample_value <= nxt.value;
          in_sample_is_nan <= nxt.is_nan;
          in_last_band <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random bursts, plus one long hold that lets the block fill up and stall
  // the sender.
  always @(posedge clk) begin : result_stall
    int rx_gap_left;
    int long_hold_left;
    bit long_hold_done;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap_left = 0;
      long_hold_left = 0;
      long_hold_done = 1'b0;
    end else if (long_hold_left != 0) begin
      out_stall <= 1'b1;
      long_hold_left = long_hold_left - 1;
    end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
      out_stall <= 1'b1;
      long_hold_left = LONG_HOLD_LEN - 1;
      long_hold_done = 1'b1;
    end else if (rx_gap_left != 0) begin
      out_stall <= 1'b1;
      rx_gap_left = rx_gap_left - 1;
    end else if (!quiet_tail && $urandom_range(99) < idle_pct) begin
      out_stall <= 1'b1;
      rx_gap_left = $urandom_range(7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_bit(input string field, input logic want_v, input logic got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0b, got %0b", field, want_v, got_v);
      mismatches++;
    end
  endtask

  // Result monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : result_monitor
    mask_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $error("result transaction with no sample pending: band_flag=%0b pixel_flag=%0b",
               out_band_flag, out_pixel_flag);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_bit("band_flag", want.band_flag, out_band_flag);
        check_bit("pixel_flag", want.pixel_flag, out_pixel_flag);
        check_bit("pixel_done", want.pixel_done, out_pixel_done);
        if (want.pixel_done)
          pixels_closed++;
        if (want.band_flag)
          flags_raised++;
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Wait until the sender is drained and every prediction has been matched, then let the
  // pipeline settle. Checked on the falling edge so the clocked processes have all run.
  task automatic wait_idle();
    do
      @(negedge clk);
    while (!(sample_backlog.size() == 0 && !in_valid && pending_results.size() == 0));
    repeat (4) @(posedge clk);
  endtask

  // One write: setup cycle, access cycle, done at the edge where pready is seen high.
  task automatic write_reg(input logic [npm_pkg::IDX_W-1:0] idx, input logic [63:0] val);
    int k;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do
      @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == npm_pkg::REG_MODE) begin
      cfg_m.mode = val[0];
    end else if (idx == npm_pkg::REG_SLAB_CNT) begin
      cfg_m.slab_cnt = val[1:0];
    end else begin
      k = int'(idx) - npm_pkg::REG_IVL_BASE;
      ivl_m[k / npm_pkg::REG_BANDS][k % npm_pkg::REG_BANDS] = val;
    end
  endtask

  // Write mode and slab count, and optionally the whole interval table from ivl_next.
  task automatic program_block(input logic mode, input logic [1:0] slabs, input bit with_ivl);
    write_reg(npm_pkg::REG_MODE, 64'(mode));
    write_reg(npm_pkg::REG_SLAB_CNT, 64'(slabs));
    if (with_ivl) begin
      for (int s = 0; s < npm_pkg::REG_SLABS; s++)
        for (int b = 0; b < npm_pkg::REG_BANDS; b++)
          write_reg(npm_pkg::IDX_W'(npm_pkg::REG_IVL_BASE + s * npm_pkg::REG_BANDS + b),
                    ivl_next[s][b]);
    end
    settings_count++;
  endtask

  task automatic push_sample(input logic [1:0] band, input logic signed [31:0] value,
                             input logic is_nan, input logic last);
    band_sample_t smp;
    smp = '{band, value, is_nan, last};
    sample_backlog = {sample_backlog, smp};
  endtask

  // Random interval: full range, single point, empty, fully random, or a narrow window.
  function automatic npm_pkg::ivl_t random_interval();
    npm_pkg::ivl_t v;
    logic signed [31:0] mid;
    int unsigned span;
    case ($urandom_range(9))
      0: begin
        v.lo = S_MIN;
        v.hi = S_MAX;
      end
      1: begin
        v.lo = $urandom;
        v.hi = v.lo;
      end
      2: begin
        v.lo = $urandom;
        v.hi = v.lo - $urandom_range(1000, 1);
      end
      3: begin
        v.lo = $urandom;
        v.hi = $urandom;
      end
      default: begin
        mid = ($urandom_range(1)) ? $urandom : ($urandom_range(20000) - 10000);
        span = $urandom_range(2000);
        v.lo = mid - span;
        v.hi = mid + span;
      end
    endcase
    return v;
  endfunction

  // Sample value biased toward the edges of the programmed intervals and the extremes.
  function automatic logic signed [31:0] pick_value(input logic [1:0] band);
    npm_pkg::ivl_t iv;
    logic signed [31:0] v;
    iv = ivl_m[$urandom_range(npm_pkg::REG_SLABS - 1)][(band < NUM_BANDS) ? band : 2'd0];
    case ($urandom_range(9))
      0: v = S_MIN;
      1: v = S_MAX;
      2: v = $urandom_range(1) ? 32'sd0 : -32'sd1;
      3, 4, 5: v = ($urandom_range(1) ? iv.lo : iv.hi) + $urandom_range(2) - 1;
      6: v = $urandom_range(4000) - 2000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Mostly well-formed pixels (bands in order, last on the final one), some loose samples
  // with any band and any last mark.
  task automatic queue_random_samples(input int count);
    int made;
    int bands;
    logic [1:0] band;
    made = 0;
    while (made < count) begin
      if ($urandom_range(9) != 0) begin
        bands = $urandom_range(NUM_BANDS, 1);
        for (int b = 0; b < bands; b++) begin
          push_sample(2'(b), pick_value(2'(b)), ($urandom_range(11) == 0), (b == bands - 1));
          made++;
        end
      end else begin
        band = 2'($urandom_range(3));
        push_sample(band, pick_value(band), 1'($urandom_range(1)), 1'($urandom_range(1)));
        made++;
      end
    end
  endtask

  initial begin : stimulus
    logic phase_mode [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    int phase_idle [6] = '{15, 0, 30, 8, 20, 12};

    for (int s = 0; s < npm_pkg::REG_SLABS; s++)
      for (int b = 0; b < npm_pkg::REG_BANDS; b++)
        ivl_m[s][b] = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: no slab active, so only NaN can raise a flag.
    @(negedge clk);
    push_sample(2'd0, 32'sd0, 1'b0, 1'b0);
    push_sample(2'd1, S_MAX, 1'b1, 1'b0);
    push_sample(2'd2, S_MIN, 1'b0, 1'b1);
    push_sample(2'd0, 32'sd0, 1'b1, 1'b1);

    // No-data mode, both slabs: full range, boundary window, empty interval and
    // single-point intervals at zero and at both extremes.
    wait_idle();
    ivl_next[0][0] = '{hi: S_MAX, lo: S_MIN};
    ivl_next[0][1] = '{hi: 32'sd100, lo: -32'sd100};
    ivl_next[0][2] = '{hi: -32'sd5, lo: 32'sd5};
    ivl_next[1][0] = '{hi: 32'sd0, lo: 32'sd0};
    ivl_next[1][1] = '{hi: S_MAX, lo: S_MAX};
    ivl_next[1][2] = '{hi: S_MIN, lo: S_MIN};
    program_block(1'b0, 2'd2, 1'b1);
    @(negedge clk);
    push_sample(2'd0, S_MIN, 1'b0, 1'b0);
    push_sample(2'd1, -32'sd100, 1'b0, 1'b0);
    push_sample(2'd2, 32'sd0, 1'b0, 1'b1);
    push_sample(2'd1, 32'sd101, 1'b0, 1'b0);
    push_sample(2'd1, S_MAX, 1'b0, 1'b0);
    push_sample(2'd3, 32'sd0, 1'b0, 1'b1);
    push_sample(2'd2, S_MIN, 1'b0, 1'b1);
    // Leave this pixel open across the mode change below.
    push_sample(2'd0, S_MAX, 1'b0, 1'b0);

    // Valid-range mode with a slab count above the maximum.
    wait_idle();
    program_block(1'b1, 2'd3, 1'b0);
    @(negedge clk);
    push_sample(2'd1, -32'sd101, 1'b0, 1'b1);
    push_sample(2'd0, -32'sd1, 1'b0, 1'b0);
    push_sample(2'd3, S_MAX, 1'b0, 1'b0);
    push_sample(2'd2, 32'sd5, 1'b1, 1'b1);
    push_sample(2'd1, 32'sd100, 1'b0, 1'b1);
    push_sample(2'd2, -32'sd5, 1'b0, 1'b0);

    // Random phases, each with fresh intervals, a programmed mode, a new slab count and its own
    // idling rate. The sender pauses for a full drain before each reprogramming.
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      for (int s = 0; s < npm_pkg::REG_SLABS; s++)
        for (int b = 0; b < npm_pkg::REG_BANDS; b++)
          ivl_next[s][b] = random_interval();
      program_block(phase_mode[p], 2'(p % 4), 1'b1);
      @(negedge clk);
      idle_pct = phase_idle[p];
      queue_random_samples(PHASE_ITEMS);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Covered %0d samples in %0d register settings: %0d pixels closed, %0d band flags.",
             accepted_count, settings_count, pixels_closed, flags_raised);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/npm_pkg.sv
design/npm_regs.sv
design/npm_match.sv
design/nodata_pixel_mask.sv
design/npm_chk.sv
sim/nodata_pixel_mask_test.sv
